// File: design/sbtg_pkg.sv
// Package for the sine beep tone generator: widths, register indexes, beat structs
// and the constant quarter-wave sine function used to build the lookup table.
// No dependencies.
package sbtg_pkg;

   localparam int TAIL_FRAMES     = 256;
   localparam int SINE_INDEX_BITS = 10;
   localparam int PHASE_BITS      = 32;

   localparam int QBITS     = SINE_INDEX_BITS - 2;
   localparam int QN        = 1 << QBITS;
   localparam int TAIL_W    = $clog2(TAIL_FRAMES + 1);
   localparam int STEP_W    = 32;
   localparam int TONE_W    = 20;
   localparam int AMP_W     = 13;
   localparam int SAMPLE_W  = 14;
   localparam int SINE_W    = 15;
   localparam int PROD_W    = SINE_W + AMP_W;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [AMP_W-1:0] AMP_RESET = 13'd6000;
   localparam longint Q30_ONE = 64'sd1073741824;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PHASE_STEP  = 2'd0,
      CSR_TONE_FRAMES = 2'd1,
      CSR_AMPLITUDE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [STEP_W-1:0] phase_step;
      logic [TONE_W-1:0] tone_frames;
      logic [AMP_W-1:0]  amplitude;
   } cfg_type;

   typedef struct packed {
      logic                       valid;
      logic [SINE_INDEX_BITS-1:0] index;
      logic                       tone_on;
      logic                       last;
   } tone_beat_type;

   // Quarter-wave sine in Q1.15 for offset q in 0..QN, evaluated at elaboration.
   function automatic int quarter_sine(input int q);
      longint z;
      longint z2;
      longint p;
      longint s;
      z  = (longint'(q) * Q30_ONE) / QN;
      z2 = (z * z) / Q30_ONE;
      p  = 172273;
      p  = -5026995 + (p * z2) / Q30_ONE;
      p  = 85569306 + (p * z2) / Q30_ONE;
      p  = -693598669 + (p * z2) / Q30_ONE;
      p  = 1686629713 + (p * z2) / Q30_ONE;
      s  = (z * p) / Q30_ONE;
      if (s < 0) s = 0;
      s = (s * 32767 + (Q30_ONE / 2)) / Q30_ONE;
      if (s > 32767) s = 32767;
      return int'(s);
   endfunction

endpackage

// File: design/sine_beep_tone_generator.sv
// Top level of the sine beep tone generator: configuration registers, sequencer
// and shaper. Uses sbtg_pkg, sbtg_sequencer and sbtg_shaper.
//
//   Channel   Direction  Handshake            Beat
//   req_      in         req_valid/req_stall  start_req
//   rsp_      out        rsp_valid/rsp_stall  sample, tone_on, last
//   csr_      in         csr_wr_en            csr_index, csr_wdata
//
// One beat is accepted every cycle while req_stall is low; its result passes through the
// sequencer stage register and the shaper result register. The rate is set by the phase
// accumulator add in the sequencer stage. Reset is synchronous and clears the counters,
// phase and valid flags. A stalled result holds its stage; the input stalls only when both stages are full.
module sine_beep_tone_generator
   import sbtg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_start_req,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_tone_on,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   tone_beat_type beat;
   logic          out_free;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PHASE_STEP:  cfg_in.phase_step  = csr_wdata[STEP_W-1:0];
            CSR_TONE_FRAMES: cfg_in.tone_frames = csr_wdata[TONE_W-1:0];
            CSR_AMPLITUDE:   cfg_in.amplitude   = csr_wdata[AMP_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step  <= '0;
         cfg_ff.tone_frames <= '0;
         cfg_ff.amplitude   <= AMP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbtg_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .cfg           (cfg_ff),
      .out_free      (out_free),
      .beat          (beat)
   );

   sbtg_shaper u_shaper (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .amplitude   (cfg_ff.amplitude),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_tone_on (rsp_tone_on),
      .rsp_last    (rsp_last)
   );

endmodule

// File: design/sbtg_sequencer.sv
// Beep sequencer: phase accumulator, tone and tail counters, and the stage register
// that hands each beat's sine index and flags to the shaper. Uses sbtg_pkg.
module sbtg_sequencer
   import sbtg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_start_req,
   input  cfg_type       cfg,
   input  logic          out_free,
   output tone_beat_type beat
);

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [TONE_W-1:0]     tone_left_ff, tone_left_in;
   logic [TAIL_W-1:0]     tail_left_ff, tail_left_in;
   tone_beat_type         beat_ff, beat_in;

   logic                  accept;
   logic [PHASE_BITS-1:0] phase_cur;
   logic [TONE_W-1:0]     tone_cur;
   logic [TAIL_W-1:0]     tail_cur;

   assign req_stall = beat_ff.valid & ~out_free;
   assign accept    = req_valid & ~req_stall;
   assign beat      = beat_ff;

   always_comb begin
      phase_cur = req_start_req ? '0 : phase_ff;
      tone_cur  = req_start_req ? cfg.tone_frames : tone_left_ff;
      tail_cur  = req_start_req ? TAIL_W'(TAIL_FRAMES) : tail_left_ff;

      phase_in     = phase_ff;
      tone_left_in = tone_left_ff;
      tail_left_in = tail_left_ff;
      beat_in      = beat_ff;
      if (out_free) begin
         beat_in.valid = 1'b0;
      end

      if (accept) begin
         phase_in      = phase_cur;
         tone_left_in  = tone_cur;
         tail_left_in  = tail_cur;
         beat_in.valid   = 1'b1;
         beat_in.index   = phase_cur[PHASE_BITS-1 -: SINE_INDEX_BITS];
         beat_in.tone_on = 1'b0;
         beat_in.last    = 1'b0;
         if (tone_cur != '0) begin
            beat_in.tone_on = 1'b1;
            phase_in        = phase_cur + cfg.phase_step[PHASE_BITS-1:0];
            tone_left_in    = tone_cur - TONE_W'(1);
         end else if (tail_cur != '0) begin
            beat_in.last = (tail_cur == TAIL_W'(1));
            tail_left_in = tail_cur - TAIL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         tone_left_ff  <= '0;
         tail_left_ff  <= '0;
         beat_ff.valid <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         tone_left_ff  <= tone_left_in;
         tail_left_ff  <= tail_left_in;
         beat_ff.valid <= beat_in.valid;
      end
      beat_ff.index   <= beat_in.index;
      beat_ff.tone_on <= beat_in.tone_on;
      beat_ff.last    <= beat_in.last;
   end

endmodule

// File: design/sbtg_shaper.sv
// Sample shaper: quarter-wave sine lookup, amplitude scaling with truncation toward
// zero, and the result register that drives the rsp_ channel. Uses sbtg_pkg.
module sbtg_shaper
   import sbtg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  tone_beat_type              beat,
   input  logic [AMP_W-1:0]           amplitude,
   output logic                       out_free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_tone_on,
   output logic                       rsp_last
);

   localparam logic [SINE_W-1:0] SINE_PEAK = SINE_W'(quarter_sine(QN));

   logic [SINE_W-1:0] sine_rom [QN];

   for (genvar gi = 0; gi < QN; gi++) begin : g_rom
      assign sine_rom[gi] = SINE_W'(quarter_sine(gi));
   end

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       tone_on_ff;
   logic                       last_ff;

   logic                       load;
   logic [1:0]                 quad;
   logic [QBITS-1:0]           offset;
   logic [QBITS-1:0]           rom_index;
   logic [SINE_W-1:0]          magnitude;
   logic [PROD_W-1:0]          product;
   logic [SAMPLE_W-1:0]        scaled;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign load     = beat.valid & out_free;

   always_comb begin
      quad      = beat.index[SINE_INDEX_BITS-1 -: 2];
      offset    = beat.index[QBITS-1:0];
      rom_index = quad[0] ? (~offset) + QBITS'(1) : offset;
      if (quad[0] && (offset == '0)) begin
         magnitude = SINE_PEAK;
      end else begin
         magnitude = sine_rom[rom_index];
      end
      product = PROD_W'(magnitude) * PROD_W'(amplitude);
      scaled  = {1'b0, product[PROD_W-1 -: AMP_W]};
      if (!beat.tone_on) begin
         sample_in = '0;
      end else if (quad[1]) begin
         sample_in = -$signed(scaled);
      end else begin
         sample_in = $signed(scaled);
      end
      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         sample_ff  <= sample_in;
         tone_on_ff <= beat.tone_on;
         last_ff    <= beat.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = sample_ff;
   assign rsp_tone_on = tone_on_ff;
   assign rsp_last    = last_ff;

endmodule

// File: tb/sine_sample_checker.sv
`timescale 1ns / 1ps
// Checker for the sine beep tone generator: a beat-level model of the phase, tone and tail
// counters predicts every output beat and compares it with the block. Uses sbtg_pkg.
module sine_sample_checker
   import sbtg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_start_req,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_sample,
   input  logic                       rsp_tone_on,
   input  logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata,
   output int                         fail_count,
   output int                         pending,
   output int                         beat_count,
   output int                         tone_count,
   output int                         end_count
);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       tone_on;
      logic                       last;
   } sample_beat_type;

   int                    sine_lut [0:(1 << SINE_INDEX_BITS) - 1];
   logic [STEP_W-1:0]     step_reg;
   logic [TONE_W-1:0]     frames_reg;
   logic [AMP_W-1:0]      amp_reg;
   logic [PHASE_BITS-1:0] phase;
   logic [TONE_W-1:0]     tone_left;
   logic [TAIL_W-1:0]     tail_left;
   sample_beat_type       sample_queue [$];
   sample_beat_type       want;

   function automatic int quarter_wave_q15(input int offset);
      longint x;
      longint x2;
      longint poly;
      longint y;
      x    = (longint'(offset) * Q30_ONE) / QN;
      x2   = (x * x) / Q30_ONE;
      poly = 172273;
      poly = -5026995 + (poly * x2) / Q30_ONE;
      poly = 85569306 + (poly * x2) / Q30_ONE;
      poly = -693598669 + (poly * x2) / Q30_ONE;
      poly = 1686629713 + (poly * x2) / Q30_ONE;
      y    = (x * poly) / Q30_ONE;
      if (y < 0) y = 0;
      y = (y * 32767 + (Q30_ONE / 2)) / Q30_ONE;
      if (y > 32767) y = 32767;
      return int'(y);
   endfunction

   function automatic sample_beat_type next_sample(input logic start);
      sample_beat_type            beat;
      logic [SINE_INDEX_BITS-1:0] idx;
      int                         product;
      beat = '0;
      if (start) begin
         phase     = '0;
         tone_left = frames_reg;
         tail_left = TAIL_W'(TAIL_FRAMES);
      end
      if (tone_left != 0) begin
         idx          = phase[PHASE_BITS-1 -: SINE_INDEX_BITS];
         product      = int'(amp_reg) * sine_lut[idx];
         beat.sample  = SAMPLE_W'(product / 32768);
         beat.tone_on = 1'b1;
         phase        = phase + step_reg[PHASE_BITS-1:0];
         tone_left    = tone_left - 1'b1;
      end else if (tail_left != 0) begin
         beat.last = (tail_left == 1);
         tail_left = tail_left - 1'b1;
      end
      return beat;
   endfunction

   initial begin
      logic [1:0] quad;
      int         offset;
      int         mag;
      for (int i = 0; i < (1 << SINE_INDEX_BITS); i++) begin
         quad        = 2'(i >> QBITS);
         offset      = i % QN;
         mag         = quarter_wave_q15(quad[0] ? QN - offset : offset);
         sine_lut[i] = quad[1] ? -mag : mag;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         step_reg   = '0;
         frames_reg = '0;
         amp_reg    = AMP_RESET;
         phase      = '0;
         tone_left  = '0;
         tail_left  = '0;
         sample_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PHASE_STEP: begin
                  step_reg = csr_wdata[STEP_W-1:0];
               end
               CSR_TONE_FRAMES: begin
                  frames_reg = csr_wdata[TONE_W-1:0];
               end
               CSR_AMPLITUDE: begin
                  amp_reg = csr_wdata[AMP_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) sample_queue.push_back(next_sample(req_start_req));
         if (rsp_valid && !rsp_stall) begin
            beat_count++;
            if (rsp_tone_on) tone_count++;
            if (rsp_last) end_count++;
            if (sample_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected beat: sample %0d tone_on %0b last %0b",
                           rsp_sample, rsp_tone_on, rsp_last);
               fail_count++;
            end else begin
               want = sample_queue.pop_front();
               if (rsp_sample !== want.sample || rsp_tone_on !== want.tone_on ||
                   rsp_last !== want.last) begin
                  if (fail_count < 10)
                     $display({"Mismatch on beat %0d: expected sample %0d tone_on %0b ",
                               "last %0b, got sample %0d tone_on %0b last %0b"},
                              beat_count, want.sample, want.tone_on, want.last,
                              rsp_sample, rsp_tone_on, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      pending = sample_queue.size();
   end

endmodule

// File: tb/sine_beep_tone_generator_test.sv
`timescale 1ns / 1ps
// Testbench top for the sine beep tone generator: clock, reset, register settings and
// start/tick stimulus under varied idling. Uses sbtg_pkg, sine_sample_checker and the block.
module sine_beep_tone_generator_test;
   import sbtg_pkg::*;

   localparam int RANDOM_BEATS   = 1950;
   localparam int SETTING_PHASES = 6;
   localparam int PHASE_BUDGET   = RANDOM_BEATS / SETTING_PHASES;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_start_req;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_tone_on;
   logic                       rsp_last;
   logic                       csr_wr_en;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_W-1:0]           csr_wdata;

   int fail_count;
   int pending;
   int beat_count;
   int tone_count;
   int end_count;
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int setting_count     = 0;
   int cycle_count       = 0;

   sine_beep_tone_generator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .rsp_tone_on   (rsp_tone_on),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   sine_sample_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample    (rsp_sample),
      .rsp_tone_on   (rsp_tone_on),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .beat_count    (beat_count),
      .tone_count    (tone_count),
      .end_count     (end_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL sine_beep_tone_generator");
         $finish;
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 47;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 47;
         end
         default: begin
            sender_idle_pct    = 11;
            receiver_stall_pct = 11;
         end
      endcase
   endtask

   task automatic send_beat(input logic start);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_start_req = start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input logic [STEP_W-1:0] step, input logic [TONE_W-1:0] frames,
                            input logic [AMP_W-1:0] amp);
      logic [CSR_W-1:0] noise;
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      noise     = $urandom;
      csr_wr_en = 1'b1;
      csr_index = CSR_PHASE_STEP;
      csr_wdata = step;
      @(negedge clock);
      csr_index = CSR_TONE_FRAMES;
      csr_wdata = {noise[CSR_W-1:TONE_W], frames};
      @(negedge clock);
      csr_index = CSR_AMPLITUDE;
      csr_wdata = {noise[CSR_W-AMP_W-1:0], amp};
      @(negedge clock);
      csr_index = CSR_SPARE;
      csr_wdata = $urandom;
      @(negedge clock);
      csr_wr_en = 1'b0;
      setting_count++;
   endtask

   initial begin
      logic [STEP_W-1:0] step;
      logic [TONE_W-1:0] frames;
      logic [AMP_W-1:0]  amp;
      int                sent;
      int                run;
      int                kind;
      logic              start_first;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_start_req = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings, zero-length beep, quarter-turn steps at full 13-bit
      // amplitude, restarts, a backward phase sweep, and amplitude changed mid-beep.
      set_idling(0);
      send_beat(1'b0);
      send_beat(1'b1);
      send_beat(1'b0);
      send_beat(1'b0);
      configure(32'h4000_0000, 20'd6, 13'h1FFF);
      send_beat(1'b1);
      repeat (5) send_beat(1'b0);
      send_beat(1'b1);
      repeat (2) send_beat(1'b0);
      configure(32'hFFFF_FFFF, 20'hFFFFF, 13'd6000);
      send_beat(1'b1);
      repeat (4) send_beat(1'b0);
      send_beat(1'b1);
      send_beat(1'b0);
      configure(32'hFFFF_FFFF, 20'hFFFFF, 13'd0);
      repeat (2) send_beat(1'b0);
      configure(32'h0080_0000, 20'd1, 13'd1);
      send_beat(1'b1);
      repeat (2) send_beat(1'b0);

      for (int p = 0; p < SETTING_PHASES; p++) begin
         if (p == 0) step = '0;
         else if (p == 1) step = 32'hFFFF_FFFF;
         else if ($urandom_range(3) == 0) step = STEP_W'($urandom_range(0, 1 << 24));
         else step = $urandom;
         if (p == 2) frames = '0;
         else if (p == 3) frames = 20'hFFFFF;
         else frames = TONE_W'($urandom_range(1, 60));
         if (p == 4) amp = '0;
         else if (p == 5) amp = 13'h1FFF;
         else if ($urandom_range(4) == 0) amp = AMP_W'($urandom_range(6001, 8191));
         else amp = AMP_W'($urandom_range(0, 6000));
         configure(step, frames, amp);
         set_idling(p % 4);
         sent = 0;
         while (sent < PHASE_BUDGET) begin
            kind        = $urandom_range(7);
            start_first = 1'b1;
            if (kind == 7) begin
               run         = $urandom_range(1, 20);
               start_first = 1'b0;
            end else if ((sent == 0 || kind < 5) &&
                         int'(frames) + TAIL_FRAMES <= PHASE_BUDGET - sent) begin
               run = int'(frames) + TAIL_FRAMES + $urandom_range(0, 3);
            end else begin
               run = $urandom_range(1, (PHASE_BUDGET - sent < 300) ? PHASE_BUDGET - sent : 300);
            end
            for (int i = 0; i < run; i++) send_beat(i == 0 && start_first);
            sent += run;
         end
      end

      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Checked %0d sample beats across %0d register settings and four idling modes.",
               beat_count, setting_count);
      $display("Of these, %0d were tone samples and %0d closed a beep's silence tail.",
               tone_count, end_count);
      if (fail_count == 0) begin
         $display("PASS sine_beep_tone_generator");
      end else begin
         $display("FAIL sine_beep_tone_generator");
      end
      $finish;
   end

endmodule
